// ===== rtl/feedback_queue_process_scheduler_unit_macros.svh =====
// Assertion macros for the feedback queue process scheduler.
// Included by the top level only; depends on nothing else.
`ifndef FEEDBACK_QUEUE_PROCESS_SCHEDULER_UNIT_MACROS_SVH
`define FEEDBACK_QUEUE_PROCESS_SCHEDULER_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define FQPS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fqps: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define FQPS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fqps: next-cycle check failed");

`endif

// ===== rtl/fqps_pkg.sv =====
// Shared types and constants for the feedback queue process scheduler.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package fqps_pkg;

    localparam int NUM_LEVELS   = 3;
    localparam int LOWEST_LEVEL = 2;
    localparam int PID_W        = 16;
    localparam int LVL_W        = 2;
    localparam int SLICE_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_POLICY_MODE  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL0_LIMIT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL1_LIMIT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LEVEL2_LIMIT = 2'd3;

    typedef enum logic [1:0] {
        CMD_ADD    = 2'd0,
        CMD_PICK   = 2'd1,
        CMD_REPORT = 2'd2
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_NO_PICK = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        t_cmd               command;
        logic [PID_W-1:0]   process_id;
        logic               still_alive;
    } t_item;

    typedef struct packed {
        t_status            status;
        logic [PID_W-1:0]   chosen_id;
        logic [LVL_W-1:0]   chosen_level;
    } t_result;

    // Controller to datapath commands.
    typedef struct packed {
        logic issue;    // latch transaction, start front read
        logic commit;   // apply update, load result register
    } t_ctl;

endpackage

`default_nettype wire

// ===== rtl/feedback_queue_process_scheduler_unit.sv =====
// Top level of the feedback queue process scheduler: sequencer plus datapath.
// Depends on fqps_pkg, fqps_ctrl, fqps_dpath and the assertion macro header.
//
// Usage:
//   Input channel (i_valid / o_stall / i_item) carries one command per
//   transaction: add a pid to level 0, pick the next pid to run, or report
//   the end of the picked pid's quantum. Output channel (o_valid / i_stall /
//   o_result) returns exactly one result per command, in order.
//   Configuration (i_cfg_we / i_cfg_index / i_cfg_wdata) sets the policy mode
//   and the three slice limits; write only while the block is idle.
//   The command is latched, and its front read issued, on accept; the result
//   is loaded into the output register when the execute state commits. The
//   queue memory read data is used (and any requeue written) in the execute
//   state, and o_stall stays high there, so a new command is accepted only
//   after the previous one has committed.
//   A new command is accepted while a finished result waits; if the receiver
//   keeps stalling, that command waits in its execute cycle until the output
//   register frees, and o_stall stays high meanwhile.
//   Reset empties all levels, clears slice counts and any pending pick, and
//   restores feedback mode with limits 1, 2 and 4. Queue memory contents are
//   not cleared; no reset sweep is needed.
`timescale 1ns / 1ps
`default_nettype none
`include "feedback_queue_process_scheduler_unit_macros.svh"

module feedback_queue_process_scheduler_unit
    import fqps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_valid,
    output logic                       o_stall,
    input  wire t_item                 i_item,
    output logic                       o_valid,
    input  wire logic                  i_stall,
    output t_result                    o_result,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_ctl ctl;

    fqps_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_ctl   (ctl)
    );

    fqps_dpath #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (ctl),
        .i_item      (i_item),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_result    (o_result)
    );

    `FQPS_ASSERT_NEXT(a_issue_then_busy, i_clk, i_rst_n, ctl.issue, o_stall)
    `FQPS_ASSERT_NEXT(a_commit_then_valid, i_clk, i_rst_n, ctl.commit, o_valid)
    `FQPS_ASSERT_SAME(a_commit_not_over_held, i_clk, i_rst_n, ctl.commit, !(o_valid && i_stall))
    `FQPS_ASSERT_SAME(a_issue_commit_excl, i_clk, i_rst_n, ctl.issue, !ctl.commit)

endmodule

`default_nettype wire

// ===== rtl/fqps_ctrl.sv =====
// Sequencer of the scheduler: accept, execute, and output valid tracking.
// Depends on fqps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqps_ctrl
    import fqps_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_valid,
    output logic      o_stall,
    output logic      o_valid,
    input  wire logic i_stall,
    output t_ctl      o_ctl
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_comb begin
        n_state      = r_state;
        o_ctl.issue  = 1'b0;
        o_ctl.commit = 1'b0;
        o_stall      = 1'b1;
        case (r_state)
            S_IDLE: begin
                o_stall = 1'b0;
                if (i_valid) begin
                    o_ctl.issue = 1'b1;
                    n_state     = S_EXEC;
                end
            end
            S_EXEC: begin
                // hold while the previous result is still stalled
                if (!r_out_valid || !i_stall) begin
                    o_ctl.commit = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
        n_out_valid = o_ctl.commit ? 1'b1 : (r_out_valid && i_stall);
    end

    assign o_valid = r_out_valid;

endmodule

`default_nettype wire

// ===== rtl/fqps_dpath.sv =====
// Datapath of the scheduler: queue memory, level heads and counts, slice
// counters, configuration registers and result register. Depends on fqps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module fqps_dpath
    import fqps_pkg::*;
#(
    parameter int QUEUE_DEPTH = 64
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_ctl                  i_ctl,
    input  wire t_item                 i_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_result                    o_result
);

    localparam int HW        = $clog2(QUEUE_DEPTH);
    localparam int CW        = $clog2(QUEUE_DEPTH + 1);
    localparam int MEM_DEPTH = NUM_LEVELS * QUEUE_DEPTH;
    localparam int AW        = $clog2(MEM_DEPTH);
    localparam logic [AW-1:0] BASE1 = AW'(QUEUE_DEPTH);
    localparam logic [AW-1:0] BASE2 = AW'(2 * QUEUE_DEPTH);

    // configuration
    logic               r_mode;
    logic [SLICE_W-1:0] r_limit [NUM_LEVELS];

    // queue state
    logic [HW-1:0]      r_head    [NUM_LEVELS];
    logic [HW-1:0]      n_head    [NUM_LEVELS];
    logic [CW-1:0]      r_count   [NUM_LEVELS];
    logic [CW-1:0]      n_count   [NUM_LEVELS];
    logic [SLICE_W-1:0] r_slice   [NUM_LEVELS];
    logic [SLICE_W-1:0] n_slice   [NUM_LEVELS];
    logic [CW-1:0]      r_total, n_total;
    logic [LVL_W-1:0]   r_picked, n_picked;
    logic               r_pending, n_pending;

    // transaction and memory
    t_item              r_item;
    t_result            r_res, n_res;
    logic [PID_W-1:0]   r_mem [MEM_DEPTH];
    logic [PID_W-1:0]   r_rdata;

    logic               found;
    logic [LVL_W-1:0]   srch_lvl;
    logic [LVL_W-1:0]   rd_lvl;
    logic [AW-1:0]      rd_addr;
    logic               wr_en;
    logic [LVL_W-1:0]   wr_lvl;
    logic [PID_W-1:0]   wr_data;
    logic [AW-1:0]      wr_addr;
    logic [LVL_W-1:0]   dest;
    logic [SLICE_W-1:0] inc;
    logic [HW-1:0]      head_nxt;

    function automatic logic [AW-1:0] level_base(input logic [LVL_W-1:0] lvl);
        logic [AW-1:0] b;
        case (lvl)
            2'd1:    b = BASE1;
            2'd2:    b = BASE2;
            default: b = '0;
        endcase
        return b;
    endfunction

    function automatic logic [HW-1:0] tail_pos(input logic [HW-1:0] h,
                                               input logic [CW-1:0] c);
        logic [CW:0] s;
        s = (CW+1)'(h) + (CW+1)'(c);
        if (s >= (CW+1)'(QUEUE_DEPTH)) begin
            s = s - (CW+1)'(QUEUE_DEPTH);
        end
        return s[HW-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b1;
            r_limit[0] <= SLICE_W'(1);
            r_limit[1] <= SLICE_W'(2);
            r_limit[2] <= SLICE_W'(4);
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_POLICY_MODE:  r_mode     <= i_cfg_wdata[0];
                CFG_LEVEL0_LIMIT: r_limit[0] <= i_cfg_wdata;
                CFG_LEVEL1_LIMIT: r_limit[1] <= i_cfg_wdata;
                CFG_LEVEL2_LIMIT: r_limit[2] <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // highest non-empty level; round robin looks at level 0 only
    always_comb begin
        found    = 1'b0;
        srch_lvl = '0;
        if (r_count[0] != '0) begin
            found = 1'b1;
        end else if (r_mode && r_count[1] != '0) begin
            found    = 1'b1;
            srch_lvl = 2'd1;
        end else if (r_mode && r_count[2] != '0) begin
            found    = 1'b1;
            srch_lvl = 2'd2;
        end
    end

    assign rd_lvl  = (i_item.command == CMD_PICK) ? srch_lvl : r_picked;
    assign rd_addr = level_base(rd_lvl) + AW'(r_head[rd_lvl]);

    always_comb begin
        for (int i = 0; i < NUM_LEVELS; i++) begin
            n_head[i]  = r_head[i];
            n_count[i] = r_count[i];
            n_slice[i] = r_slice[i];
        end
        n_total   = r_total;
        n_picked  = r_picked;
        n_pending = r_pending;
        n_res     = r_res;
        wr_en     = 1'b0;
        wr_lvl    = '0;
        wr_data   = r_item.process_id;
        dest      = (r_picked == LVL_W'(LOWEST_LEVEL)) ? r_picked : r_picked + 2'd1;
        inc       = r_slice[r_picked] + SLICE_W'(1);
        head_nxt  = (r_head[r_picked] == HW'(QUEUE_DEPTH - 1)) ? '0
                                                               : r_head[r_picked] + HW'(1);
        if (i_ctl.commit) begin
            n_res.status       = ST_OK;
            n_res.chosen_id    = '0;
            n_res.chosen_level = '0;
            case (r_item.command)
                CMD_ADD: begin
                    if (r_total >= CW'(QUEUE_DEPTH)) begin
                        n_res.status = ST_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        wr_lvl     = '0;
                        wr_data    = r_item.process_id;
                        n_count[0] = r_count[0] + CW'(1);
                        n_total    = r_total + CW'(1);
                    end
                end
                CMD_PICK: begin
                    if (found) begin
                        n_res.chosen_id    = r_rdata;
                        n_res.chosen_level = srch_lvl;
                        n_picked           = srch_lvl;
                        n_pending          = 1'b1;
                    end else begin
                        n_res.status = ST_EMPTY;
                    end
                end
                CMD_REPORT: begin
                    if (!r_pending || r_count[r_picked] == '0) begin
                        n_res.status = ST_NO_PICK;
                    end else begin
                        n_pending = 1'b0;
                        if (!r_mode) begin
                            n_head[r_picked] = head_nxt;
                            if (r_item.still_alive) begin
                                // requeue at the back of the same level
                                wr_en   = 1'b1;
                                wr_lvl  = r_picked;
                                wr_data = r_rdata;
                            end else begin
                                n_count[r_picked] = r_count[r_picked] - CW'(1);
                                n_total           = r_total - CW'(1);
                            end
                        end else if (!r_item.still_alive) begin
                            n_slice[r_picked] = '0;
                            n_head[r_picked]  = head_nxt;
                            n_count[r_picked] = r_count[r_picked] - CW'(1);
                            n_total           = r_total - CW'(1);
                        end else if (inc >= r_limit[r_picked]) begin
                            // demote, or rotate within the lowest level
                            n_slice[r_picked] = '0;
                            n_head[r_picked]  = head_nxt;
                            n_count[r_picked] = r_count[r_picked] - CW'(1);
                            n_count[dest]     = n_count[dest] + CW'(1);
                            wr_en             = 1'b1;
                            wr_lvl            = dest;
                            wr_data           = r_rdata;
                        end else begin
                            n_slice[r_picked] = inc;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // tail from pre-update values: a pop and push on one level lands there too
    assign wr_addr = level_base(wr_lvl) + AW'(tail_pos(r_head[wr_lvl], r_count[wr_lvl]));

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (i_ctl.issue) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.issue) begin
            r_item <= i_item;
        end
        r_res <= n_res;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
                r_slice[i] <= '0;
            end
            r_total   <= '0;
            r_picked  <= '0;
            r_pending <= 1'b0;
        end else begin
            for (int i = 0; i < NUM_LEVELS; i++) begin
                r_head[i]  <= n_head[i];
                r_count[i] <= n_count[i];
                r_slice[i] <= n_slice[i];
            end
            r_total   <= n_total;
            r_picked  <= n_picked;
            r_pending <= n_pending;
        end
    end

    assign o_result = r_res;

endmodule

`default_nettype wire

// ===== tb/tb_feedback_queue_process_scheduler_unit.sv =====
// Self-checking testbench for the feedback queue process scheduler: directed
// and random command streams under varied handshake idling and configurations.
// Depends on fqps_pkg and the feedback_queue_process_scheduler_unit RTL.
`timescale 1ns / 1ps

module tb_feedback_queue_process_scheduler_unit;
    import fqps_pkg::*;

    localparam int DEPTH          = 64;
    localparam int HEAD_W         = $clog2(DEPTH);
    localparam int ITEMS_PER_SEG  = 200;
    localparam int NUM_SEGMENTS   = 8;
    localparam int SETTLE_CYCLES  = 4;
    localparam int QUIET_LIMIT    = 4000;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    class run_queue_tracker;
        logic [PID_W-1:0]   ring [NUM_LEVELS][DEPTH];
        logic [HEAD_W-1:0]  head [NUM_LEVELS];
        logic [HEAD_W:0]    occupancy [NUM_LEVELS];
        logic [HEAD_W:0]    total;
        logic [SLICE_W-1:0] slices [NUM_LEVELS];
        logic [SLICE_W-1:0] limit_of [NUM_LEVELS];
        logic               feedback_mode;
        logic [LVL_W-1:0]   picked;
        logic               pick_open;
        t_result            pending_results[$];
        int refused, empty_picks, orphan_reports, demotions, results_checked;

        function new();
            for (int l = 0; l < NUM_LEVELS; l++) begin
                head[l]      = '0;
                occupancy[l] = '0;
                slices[l]    = '0;
            end
            total         = '0;
            picked        = '0;
            pick_open     = 1'b0;
            feedback_mode = 1'b1;
            limit_of[0]   = 4'd1;
            limit_of[1]   = 4'd2;
            limit_of[2]   = 4'd4;
        endfunction

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_POLICY_MODE:  feedback_mode = data[0];
                CFG_LEVEL0_LIMIT: limit_of[0] = data;
                CFG_LEVEL1_LIMIT: limit_of[1] = data;
                CFG_LEVEL2_LIMIT: limit_of[2] = data;
                default: ;
            endcase
        endfunction

        function void enqueue(int lvl, logic [PID_W-1:0] pid);
            ring[lvl][(int'(head[lvl]) + int'(occupancy[lvl])) % DEPTH] = pid;
            occupancy[lvl]++;
        endfunction

        function logic [PID_W-1:0] dequeue(int lvl);
            logic [PID_W-1:0] pid;
            pid = ring[lvl][head[lvl]];
            head[lvl] = HEAD_W'((int'(head[lvl]) + 1) % DEPTH);
            occupancy[lvl]--;
            return pid;
        endfunction

        function void note_command(t_item it);
            t_result          r;
            int               hit;
            int               top;
            logic [PID_W-1:0] pid;
            r = '0;
            r.status = ST_OK;
            case (it.command)
                CMD_ADD: begin
                    if (total >= DEPTH) begin
                        r.status = ST_FULL;
                        refused++;
                    end else begin
                        enqueue(0, it.process_id);
                        total++;
                    end
                end
                CMD_PICK: begin
                    hit = -1;
                    top = feedback_mode ? NUM_LEVELS : 1;
                    for (int l = top - 1; l >= 0; l--)
                        if (occupancy[l] != 0) hit = l;
                    if (hit >= 0) begin
                        r.chosen_id    = ring[hit][head[hit]];
                        r.chosen_level = LVL_W'(hit);
                        picked         = LVL_W'(hit);
                        pick_open      = 1'b1;
                    end else begin
                        r.status = ST_EMPTY;
                        empty_picks++;
                    end
                end
                CMD_REPORT: begin
                    if (!pick_open || occupancy[picked] == 0) begin
                        r.status = ST_NO_PICK;
                        orphan_reports++;
                    end else begin
                        pick_open = 1'b0;
                        if (!feedback_mode) begin
                            pid = dequeue(picked);
                            if (it.still_alive) enqueue(picked, pid);
                            else total--;
                        end else if (!it.still_alive) begin
                            slices[picked] = '0;
                            pid = dequeue(picked);
                            total--;
                        end else begin
                            slices[picked] = slices[picked] + 1'b1;
                            // a zero limit behaves as a limit of one here
                            if (slices[picked] >= limit_of[picked]) begin
                                slices[picked] = '0;
                                pid = dequeue(picked);
                                enqueue(picked < LOWEST_LEVEL ? picked + 1 : picked, pid);
                                demotions++;
                            end
                        end
                    end
                end
                default: ;
            endcase
            pending_results.push_back(r);
        endfunction

        function string check_result(t_result got);
            t_result want;
            string   msg;
            msg = "";
            if (pending_results.size() == 0)
                return $sformatf("unexpected result: status %0d id %h level %0d",
                                 got.status, got.chosen_id, got.chosen_level);
            want = pending_results.pop_front();
            results_checked++;
            if (got.status !== want.status)
                msg = {msg, $sformatf(" status %0d want %0d;", got.status, want.status)};
            if (got.chosen_id !== want.chosen_id)
                msg = {msg, $sformatf(" id %h want %h;", got.chosen_id, want.chosen_id)};
            if (got.chosen_level !== want.chosen_level)
                msg = {msg, $sformatf(" level %0d want %0d;", got.chosen_level,
                                      want.chosen_level)};
            if (msg != "")
                msg = $sformatf("result %0d:%s", results_checked, msg);
            return msg;
        endfunction
    endclass

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_valid = 1'b0;
    logic                  o_stall;
    t_item                 i_item = '0;
    logic                  o_valid;
    logic                  i_stall = 1'b0;
    t_result               o_result;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_wdata = '0;

    run_queue_tracker run_queues;
    int    gap_pct = 0;
    int    stall_pct = 0;
    int    items_sent = 0;
    int    mismatches = 0;
    int    quiet_cycles = 0;
    int    settings_used = 0;
    string result_msg;

    feedback_queue_process_scheduler_unit #(.QUEUE_DEPTH(DEPTH)) i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic report_mismatch(string msg);
        $display("mismatch: %s", msg);
        mismatches++;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            result_msg = run_queues.check_result(o_result);
            if (result_msg != "") report_mismatch(result_msg);
        end
    end

    // Count cycles in which no transaction moves on either side.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (i_valid && !o_stall) || (o_valid && !i_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no transaction for %0d cycles", QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    task automatic send(t_item it);
        while ($urandom_range(99) < gap_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_item  <= it;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        run_queues.note_command(it);
        if (it.command != CMD_UNUSED) items_sent++;
    endtask

    task automatic command(t_cmd c, logic [PID_W-1:0] pid, logic alive);
        t_item it;
        it.command     = c;
        it.process_id  = pid;
        it.still_alive = alive;
        send(it);
    endtask

    task automatic run_quantum(logic alive);
        command(CMD_PICK, PID_W'($urandom), 1'($urandom));
        command(CMD_REPORT, PID_W'($urandom), alive);
    endtask

    task automatic settle();
        i_valid <= 1'b0;
        while (run_queues.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write all four registers back to back; only legal while idle.
    task automatic program_scheduler(logic mode, logic [3:0] l0, logic [3:0] l1,
                                     logic [3:0] l2);
        logic [CFG_DATA_W-1:0] vals [4];
        vals[CFG_POLICY_MODE]  = {3'b000, mode};
        vals[CFG_LEVEL0_LIMIT] = l0;
        vals[CFG_LEVEL1_LIMIT] = l1;
        vals[CFG_LEVEL2_LIMIT] = l2;
        for (int idx = 0; idx < 4; idx++) begin
            i_cfg_we    <= 1'b1;
            i_cfg_index <= CFG_IDX_W'(idx);
            i_cfg_wdata <= vals[idx];
            @(posedge i_clk);
            run_queues.set_register(CFG_IDX_W'(idx), vals[idx]);
        end
        i_cfg_we <= 1'b0;
        settings_used++;
    endtask

    task automatic run_segment(int idle_kind, int target);
        int    stop;
        int    r;
        int    n;
        t_item it;
        case (idle_kind)
            0:       begin gap_pct = 0;  stall_pct = 0;  end
            1:       begin gap_pct = 62; stall_pct = 0;  end
            2:       begin gap_pct = 0;  stall_pct = 62; end
            default: begin gap_pct = 7;  stall_pct = 7;  end
        endcase
        stop = items_sent + target;
        while (items_sent < stop) begin
            r = $urandom_range(99);
            if (r < 3) begin
                // fill to capacity, then push a couple of refused adds
                while (run_queues.total < DEPTH)
                    command(CMD_ADD, PID_W'($urandom), 1'($urandom));
                repeat (2) command(CMD_ADD, PID_W'($urandom), 1'($urandom));
            end else if (r < 6) begin
                n = $urandom_range(4, 16);
                repeat (n) run_quantum(1'b0);
            end else if (r < 40) begin
                command(CMD_ADD, PID_W'($urandom), 1'($urandom));
                run_quantum($urandom_range(99) < (run_queues.total > 48 ? 45 : 80));
            end else if (r < 72) begin
                run_quantum($urandom_range(99) < (run_queues.total > 48 ? 45 : 80));
            end else if (r < 82) begin
                n = $urandom_range(1, 6);
                repeat (n) command(CMD_ADD, PID_W'($urandom), 1'($urandom));
            end else if (r < 92) begin
                it.command     = t_cmd'(2'($urandom_range(3)));
                it.process_id  = PID_W'($urandom);
                it.still_alive = 1'($urandom);
                send(it);
            end else begin
                command(CMD_PICK, PID_W'($urandom), 1'($urandom));
                command(CMD_PICK, PID_W'($urandom), 1'($urandom));
                command(CMD_REPORT, PID_W'($urandom), 1'($urandom));
            end
        end
        gap_pct = 0;
        settle();
    endtask

    initial begin
        t_item odd;
        run_queues = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: empty scheduler, unused code, pid extremes, demotion chain.
        command(CMD_PICK, 16'h0000, 1'b0);
        command(CMD_REPORT, 16'hFFFF, 1'b1);
        odd.command     = t_cmd'(CMD_UNUSED);
        odd.process_id  = 16'hFFFF;
        odd.still_alive = 1'b1;
        send(odd);
        command(CMD_ADD, 16'h0000, 1'b0);
        command(CMD_ADD, 16'hFFFF, 1'b1);
        command(CMD_ADD, 16'h5A5A, 1'b0);
        run_quantum(1'b1);
        run_quantum(1'b0);
        command(CMD_PICK, 16'h0000, 1'b0);
        command(CMD_PICK, 16'hFFFF, 1'b1);
        command(CMD_REPORT, 16'h0000, 1'b1);
        run_quantum(1'b1);
        run_quantum(1'b1);
        run_quantum(1'b1);
        command(CMD_PICK, 16'h0000, 1'b0);
        // switch to round robin with a pick still open on level 1
        settle();
        program_scheduler(1'b0, 4'd1, 4'd2, 4'd4);
        command(CMD_REPORT, 16'h0000, 1'b1);
        command(CMD_PICK, 16'h0000, 1'b0);
        command(CMD_REPORT, 16'h0000, 1'b1);
        command(CMD_ADD, 16'h1234, 1'b0);
        run_quantum(1'b1);
        run_quantum(1'b0);
        settle();

        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            case (seg)
                0: program_scheduler(1'b1, 4'd1, 4'd2, 4'd4);
                1: program_scheduler(1'b1, 4'd15, 4'd15, 4'd15);
                2: program_scheduler(1'b0, 4'($urandom_range(1, 15)), 4'd3, 4'd5);
                3: program_scheduler(1'b1, 4'd1, 4'd1, 4'd1);
                4: program_scheduler(1'b1, 4'd0, 4'd15, 4'd1);
                6: program_scheduler(1'b0, 4'd15, 4'd1, 4'd15);
                default: program_scheduler(1'b1, 4'($urandom_range(1, 15)),
                                           4'($urandom_range(1, 15)),
                                           4'($urandom_range(1, 15)));
            endcase
            run_segment(seg % 4, ITEMS_PER_SEG);
        end

        settle();
        repeat (10) @(posedge i_clk);
        if (run_queues.pending_results.size() != 0)
            report_mismatch($sformatf("%0d results never arrived",
                                      run_queues.pending_results.size()));
        $display("covered %0d commands and %0d results under %0d register settings",
                 items_sent, run_queues.results_checked, settings_used);
        $display("refused adds %0d, empty picks %0d, reports without pick %0d, demotions %0d",
                 run_queues.refused, run_queues.empty_picks, run_queues.orphan_reports,
                 run_queues.demotions);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/fqps_pkg.sv
rtl/fqps_ctrl.sv
rtl/fqps_dpath.sv
rtl/feedback_queue_process_scheduler_unit.sv
tb/tb_feedback_queue_process_scheduler_unit.sv
